// ===== src/wildcard_glob_matcher_assert.svh =====
// assertion macros for the glob matcher
`ifndef WILDCARD_GLOB_MATCHER_ASSERT_SVH
`define WILDCARD_GLOB_MATCHER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define WGM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("glob matcher assertion failed");

// next-cycle implication, disabled while in reset
`define WGM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("glob matcher assertion failed");

`endif

// ===== src/wgm_pkg.sv =====
// shared types and constants of the glob matcher
package wgm_pkg;

  localparam int LEN_W         = 6;
  localparam int BYTE_W        = 8;
  localparam int STORE_BYTES   = 32;
  localparam int NUM_BYTE_REGS = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;

  localparam logic [BYTE_W-1:0] STAR_BYTE  = 8'h2A;
  localparam logic [BYTE_W-1:0] QUERY_BYTE = 8'h3F;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH  = 3'd0,
    REG_PATTERN_BYTES_0 = 3'd1,
    REG_PATTERN_BYTES_1 = 3'd2,
    REG_PATTERN_BYTES_2 = 3'd3,
    REG_PATTERN_BYTES_3 = 3'd4
  } cfg_reg_e;

  typedef logic [NUM_BYTE_REGS-1:0][CFG_DATA_W-1:0] pattern_t;

  typedef struct packed {
    logic [BYTE_W-1:0] text_char;
    logic              no_char;
    logic              end_of_string;
  } wgm_item_t;

endpackage

// ===== src/wgm_closure.sv =====
// star closure of a position vector as a parallel prefix network
module wgm_closure #(
  parameter int W = 33
) (
  input  logic [W-1:0] v_i,
  input  logic [W-2:0] prop_i,
  output logic [W-1:0] c_o
);

  localparam int LEVELS = $clog2(W);

  logic [LEVELS:0][W-1:0] g;
  logic [LEVELS:0][W-1:0] p;

  // g: reachable, p: every star on the span into this position
  always_comb begin
    g[0] = v_i;
    p[0] = {prop_i, 1'b0};
    for (int l = 0; l < LEVELS; l++) begin
      for (int j = 0; j < W; j++) begin
        if (j >= (1 << l)) begin
          g[l+1][j] = g[l][j] | (p[l][j] & g[l][j - (1 << l)]);
          p[l+1][j] = p[l][j] & p[l][j - (1 << l)];
        end else begin
          g[l+1][j] = g[l][j];
          p[l+1][j] = p[l][j];
        end
      end
    end
  end

  assign c_o = g[LEVELS];

endmodule

// ===== src/wgm_core.sv =====
// one character step of the position vector and the end-of-string check
module wgm_core #(
  parameter int EFF = 32
) (
  input  wgm_pkg::wgm_item_t           item_i,
  input  logic [EFF:0]                 active_i,
  input  wgm_pkg::pattern_t            pattern_i,
  input  logic [wgm_pkg::LEN_W-1:0]    eff_len_i,
  output logic [EFF:0]                 active_o,
  output logic                         matched_o
);

  import wgm_pkg::*;

  localparam int W     = EFF + 1;
  localparam int IDX_W = $clog2(W);

  logic [EFF-1:0] in_len;
  logic [EFF-1:0] is_star;
  logic [EFF-1:0] hit;
  logic [EFF-1:0] prop;
  logic [EFF-1:0] star_keep;
  logic [EFF-1:0] adv;
  logic [EFF:0]   cur;
  logic [EFF:0]   nxt;
  logic [EFF:0]   after_char;
  logic [EFF:0]   fin;

  always_comb begin
    for (int i = 0; i < EFF; i++) begin
      in_len[i]  = LEN_W'(i) < eff_len_i;
      is_star[i] = pattern_i[i / 8][(i % 8) * BYTE_W +: BYTE_W] == STAR_BYTE;
      hit[i]     = (pattern_i[i / 8][(i % 8) * BYTE_W +: BYTE_W] == QUERY_BYTE) ||
                   (pattern_i[i / 8][(i % 8) * BYTE_W +: BYTE_W] == item_i.text_char);
      prop[i]    = in_len[i] & is_star[i];
    end
  end

  wgm_closure #(.W(W)) u_pre (
    .v_i    (active_i),
    .prop_i (prop),
    .c_o    (cur)
  );

  // a star position stays, any other live position advances on a hit
  assign star_keep  = cur[EFF-1:0] & prop;
  assign adv        = cur[EFF-1:0] & in_len & ~is_star & hit;
  assign nxt        = {1'b0, star_keep} | {adv, 1'b0};
  assign after_char = item_i.no_char ? active_i : nxt;

  wgm_closure #(.W(W)) u_fin (
    .v_i    (after_char),
    .prop_i (prop),
    .c_o    (fin)
  );

  assign matched_o = fin[IDX_W'(eff_len_i)];
  assign active_o  = item_i.end_of_string ? W'(1) : after_char;

endmodule

// ===== src/wildcard_glob_matcher.sv =====
// top level of the streaming glob matcher
// Streaming glob matcher.
// Input channel (in_valid_i / in_stall_o): one transaction per text byte with
// text_char_i, no_char_i and end_of_string_i. A transaction with no_char_i set
// carries no byte; with end_of_string_i also set it ends the string so far.
// Output channel (out_valid_o / out_stall_i): one transaction per string,
// matched_o high when the whole string matches the whole pattern.
// Config channel (cfg_valid_i / cfg_ready_o): index 0 is pattern_length,
// indexes 1 to 4 are the pattern bytes 0-7, 8-15, 16-23, 24-31, byte 0 in
// the low bits. cfg_ready_o is always high; other indexes are ignored.
// Throughput: one byte per cycle while in_stall_o is low; the position vector
// update (a prefix network for star runs plus per-position compares) is
// combinational. An accepted transaction waits in the input register; an
// end-of-string result is then written to the result register for the output.
// When out_stall_i holds a result, an end-of-string transaction waits in the
// input register and in_stall_o rises; non-final bytes keep flowing.
// Reset clears the configuration registers to zero, empties both registers and
// puts the matcher in its start position.
`include "wildcard_glob_matcher_assert.svh"

module wildcard_glob_matcher #(
  parameter int MAX_PATTERN = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // byte stream
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [wgm_pkg::BYTE_W-1:0]      text_char_i,
  input  logic                            no_char_i,
  input  logic                            end_of_string_i,
  // results
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            matched_o,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wgm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [wgm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import wgm_pkg::*;

  // pattern positions actually usable: parameter bounded by byte storage
  localparam int EFF = (MAX_PATTERN < STORE_BYTES) ? MAX_PATTERN : STORE_BYTES;
  localparam int W   = EFF + 1;

  // configuration
  logic [LEN_W-1:0] pattern_length_q;
  pattern_t         pattern_q;
  logic [LEN_W-1:0] eff_len;

  // input register
  logic      in_valid_q, in_valid_d;
  wgm_item_t in_item_q;
  logic      in_accept;

  // position vector, bit i: first i pattern bytes consumed
  logic [EFF:0] active_q, active_d;
  logic [EFF:0] core_active;
  logic         core_matched;

  // result register
  logic out_valid_q, out_valid_d;
  logic matched_q;
  logic out_free;
  logic fire;
  logic last_fire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_length_q <= '0;
      pattern_q        <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_PATTERN_LENGTH:  pattern_length_q <= cfg_data_i[LEN_W-1:0];
        REG_PATTERN_BYTES_0: pattern_q[0]     <= cfg_data_i;
        REG_PATTERN_BYTES_1: pattern_q[1]     <= cfg_data_i;
        REG_PATTERN_BYTES_2: pattern_q[2]     <= cfg_data_i;
        REG_PATTERN_BYTES_3: pattern_q[3]     <= cfg_data_i;
        default: ;  // writes beyond the register list have no effect
      endcase
    end
  end

  // saturate the length at the usable position count
  assign eff_len = (pattern_length_q > LEN_W'(EFF)) ? LEN_W'(EFF) : pattern_length_q;

  // a non-final byte never needs the result register; a final one needs a free slot
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && (!in_item_q.end_of_string || out_free);
  assign in_stall_o = in_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign last_fire  = fire && in_item_q.end_of_string;

  always_comb begin
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // payload register needs no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= '{text_char: text_char_i, no_char: no_char_i,
                     end_of_string: end_of_string_i};
    end
  end

  wgm_core #(.EFF(EFF)) u_core (
    .item_i    (in_item_q),
    .active_i  (active_q),
    .pattern_i (pattern_q),
    .eff_len_i (eff_len),
    .active_o  (core_active),
    .matched_o (core_matched)
  );

  assign active_d = fire ? core_active : active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= W'(1);
    end else begin
      active_q <= active_d;
    end
  end

  always_comb begin
    if (fire && in_item_q.end_of_string) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_item_q.end_of_string) begin
      matched_q <= core_matched;
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;

  // a finished string yields a result and rewinds to the start position
  `WGM_ASSERT_NEXT(a_end_gives_result, clk_i, rst_ni, last_fire, out_valid_q && active_q == W'(1))
  // back-pressure only ever holds a buffered transaction
  `WGM_ASSERT_NOW(a_stall_has_item, clk_i, rst_ni, in_stall_o, in_valid_q)
  // a result only leaves after it was taken
  `WGM_ASSERT_NOW(a_result_not_dropped, clk_i, rst_ni, $fell(out_valid_q), $past(!out_stall_i))

endmodule

// ===== tb/wgm_match_checker.sv =====
// checker that predicts glob match verdicts and compares them with the results
module wgm_match_checker #(
  parameter int MAX_PATTERN = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [wgm_pkg::BYTE_W-1:0]     text_char_i,
  input  logic                           no_char_i,
  input  logic                           end_of_string_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic                           matched_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [wgm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wgm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             error_count_o,
  output int                             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import wgm_pkg::*;

  typedef logic [STORE_BYTES:0] pos_vec_t;

  logic [LEN_W-1:0] pat_len_q;
  pattern_t         pat_q;
  pos_vec_t         live_pos_q;
  pos_vec_t         final_pos;
  int unsigned      glob_n;
  logic             want;
  logic             pending_verdicts[$];
  int               mismatches = 0;

  function automatic int unsigned glob_len();
    int unsigned n;
    n = pat_len_q;
    if (n > MAX_PATTERN) n = MAX_PATTERN;
    if (n > STORE_BYTES) n = STORE_BYTES;
    return n;
  endfunction

  function automatic logic [BYTE_W-1:0] glob_byte(int unsigned i);
    return pat_q[i / 8][(i % 8) * BYTE_W +: BYTE_W];
  endfunction

  // a star may match an empty run, so live star positions also enable the next one
  function automatic pos_vec_t star_closure(pos_vec_t v, int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (v[i] && glob_byte(i) == STAR_BYTE) v[i + 1] = 1'b1;
    end
    return v;
  endfunction

  function automatic pos_vec_t advance_positions(pos_vec_t v, logic [BYTE_W-1:0] c,
                                                 int unsigned n);
    pos_vec_t cur;
    pos_vec_t nxt;
    cur = star_closure(v, n);
    nxt = '0;
    for (int unsigned i = 0; i < n; i++) begin
      if (cur[i]) begin
        if (glob_byte(i) == STAR_BYTE) nxt[i] = 1'b1;
        else if (glob_byte(i) == QUERY_BYTE || glob_byte(i) == c) nxt[i + 1] = 1'b1;
      end
    end
    return nxt;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q  = '0;
      pat_q      = '0;
      live_pos_q = pos_vec_t'(1);
      pending_verdicts.delete();
    end else begin
      // result side first: nothing accepted at this edge can already be out
      if (out_valid_i && !out_stall_i) begin
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          $error("result with no string pending: matched=%0b", matched_i);
        end else begin
          want = pending_verdicts.pop_front();
          if (matched_i !== want) begin
            mismatches++;
            $error("field matched: expected %0b, actual %0b", want, matched_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_PATTERN_LENGTH:  pat_len_q = cfg_data_i[LEN_W-1:0];
          REG_PATTERN_BYTES_0: pat_q[0] = cfg_data_i;
          REG_PATTERN_BYTES_1: pat_q[1] = cfg_data_i;
          REG_PATTERN_BYTES_2: pat_q[2] = cfg_data_i;
          REG_PATTERN_BYTES_3: pat_q[3] = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        glob_n = glob_len();
        if (!no_char_i) live_pos_q = advance_positions(live_pos_q, text_char_i, glob_n);
        if (end_of_string_i) begin
          final_pos = star_closure(live_pos_q, glob_n);
          pending_verdicts.push_back(final_pos[glob_n]);
          live_pos_q = pos_vec_t'(1);
        end
      end
    end
    pending_o     <= pending_verdicts.size();
    error_count_o <= mismatches;
  end

endmodule

// ===== tb/tb_wildcard_glob_matcher.sv =====
// stimulus and verdict for the streaming glob matcher testbench
module tb_wildcard_glob_matcher;
  timeunit 1ns;
  timeprecision 1ps;
  import wgm_pkg::*;

  localparam int          CLK_PERIOD  = 12;
  localparam int          MAX_PAT     = 32;
  localparam int          ITEM_TARGET = 850;
  localparam int          PHASE_ITEMS = 90;
  localparam int          QUIET_TAIL  = 120;
  localparam int          HOLD_CYCLES = 48;
  localparam int          DRAIN_LIMIT = 5000;
  localparam logic [7:0]  LETTER_A    = 8'h61;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     text_char = '0;
  logic                  no_char = 1'b0;
  logic                  end_of_string = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  matched;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_PATTERN_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int check_errors;
  int pending_results;

  // knobs shared between the sender and the receiver process
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req    = 1'b0;

  // copy of the loaded pattern, used only to build strings that should match
  logic [7:0]  glob_shadow [STORE_BYTES];
  int unsigned shadow_len = 0;

  int       items_sent = 0;
  int       phase;
  int       phase_end;
  int       drain_cycles;
  pattern_t dir_pat;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  wildcard_glob_matcher #(
    .MAX_PATTERN (MAX_PAT)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .text_char_i     (text_char),
    .no_char_i       (no_char),
    .end_of_string_i (end_of_string),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .matched_o       (matched),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  wgm_match_checker #(
    .MAX_PATTERN (MAX_PAT)
  ) match_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .text_char_i     (text_char),
    .no_char_i       (no_char),
    .end_of_string_i (end_of_string),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .matched_i       (matched),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .error_count_o   (check_errors),
    .pending_o       (pending_results)
  );

  function automatic pattern_t with_byte(pattern_t p, int i, logic [7:0] b);
    p[i / 8][(i % 8) * 8 +: 8] = b;
    return p;
  endfunction

  // text bytes lean on a tiny alphabet so literals in the pattern actually hit
  function automatic logic [7:0] text_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return LETTER_A + 8'($urandom_range(0, 2));
  endfunction

  function automatic logic [7:0] glob_char();
    case ($urandom_range(0, 9))
      0, 1:    return STAR_BYTE;
      2, 3:    return QUERY_BYTE;
      4:       return 8'($urandom);
      default: return LETTER_A + 8'($urandom_range(0, 2));
    endcase
  endfunction

  // one config transaction; valid stays up so back-to-back writes need no gap
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic load_pattern(logic [LEN_W-1:0] n, pattern_t p);
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(n));
    write_reg(REG_PATTERN_BYTES_0, p[0]);
    write_reg(REG_PATTERN_BYTES_1, p[1]);
    write_reg(REG_PATTERN_BYTES_2, p[2]);
    write_reg(REG_PATTERN_BYTES_3, p[3]);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
    shadow_len = (n > STORE_BYTES) ? STORE_BYTES : n;
    for (int i = 0; i < STORE_BYTES; i++) glob_shadow[i] = p[i / 8][(i % 8) * 8 +: 8];
  endtask

  // one input transaction, with an optional idle burst in front of it;
  // valid stays high after acceptance so the next item can follow at once
  task automatic send_item(logic [7:0] c, logic nc, logic eos);
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    text_char     <= c;
    no_char       <= nc;
    end_of_string <= eos;
    do @(posedge clk_i); while (in_stall);
    // a byteless item without end marker is ignored by the block
    if (!(nc && !eos)) items_sent++;
  endtask

  // drop valid, wait for every verdict, then give byteless fillers time to retire
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_pattern(bit short_only);
    pattern_t    p;
    int unsigned n;
    int unsigned r;
    // bytes past the length are loaded with noise or all ones
    if ($urandom_range(0, 9) == 0) p = '1;
    else p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r = $urandom_range(0, 99);
    if (short_only) n = $urandom_range(1, 4);
    else if (r < 5) n = 0;
    else if (r < 75) n = $urandom_range(1, 8);
    else if (r < 93) n = $urandom_range(9, 32);
    else n = $urandom_range(33, 63);
    for (int i = 0; i < n && i < STORE_BYTES; i++) p = with_byte(p, i, glob_char());
    load_pattern(LEN_W'(n), p);
  endtask

  // a string built to match the pattern (sometimes damaged) or a random one
  task automatic send_string(bit aim_match);
    logic [7:0]  txt[$];
    int unsigned pos;
    bit          end_marker;
    end_marker = ($urandom_range(0, 6) == 0);
    if (aim_match) begin
      for (int i = 0; i < shadow_len; i++) begin
        if (glob_shadow[i] == STAR_BYTE) begin
          repeat ($urandom_range(0, 3)) txt.push_back(text_byte());
        end else if (glob_shadow[i] == QUERY_BYTE) begin
          txt.push_back(8'($urandom));
        end else begin
          txt.push_back(glob_shadow[i]);
        end
      end
      // break a share of the well-formed strings
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0: if (txt.size() > 0) begin
            pos = $urandom_range(0, txt.size() - 1);
            txt[pos] = text_byte();
          end
          1: if (txt.size() > 0) void'(txt.pop_back());
          default: txt.push_back(text_byte());
        endcase
      end
    end else begin
      repeat ($urandom_range(0, 6)) txt.push_back(text_byte());
    end
    if (txt.size() == 0) begin
      // empty string: a single byteless end marker
      send_item(8'($urandom), 1'b1, 1'b1);
    end else begin
      foreach (txt[k]) begin
        // ignored byteless filler in the middle of a string
        if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b1, 1'b0);
        send_item(txt[k], 1'b0, (k == txt.size() - 1) && !end_marker);
      end
      // string closed by a separate byteless end marker
      if (end_marker) send_item(8'($urandom), 1'b1, 1'b1);
    end
  endtask

  // receiver: random stall bursts, plus one long hold-off on request so that
  // end-of-string transactions back up into the input register
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset pattern is empty: only the empty string matches
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    quiesce();

    // length register at its maximum saturates to the full store; zero and
    // all-ones bytes are plain literals, a star run is followed by a query
    dir_pat = '0;
    dir_pat = with_byte(dir_pat, 1, 8'hFF);
    for (int i = 2; i < STORE_BYTES - 1; i++) dir_pat = with_byte(dir_pat, i, STAR_BYTE);
    dir_pat = with_byte(dir_pat, STORE_BYTES - 1, QUERY_BYTE);
    load_pattern(6'd63, dir_pat);
    // stars empty, query takes the last byte
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h41, 1'b0, 1'b1);
    // ignored byteless item mid-string, stars absorb one byte
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h12, 1'b1, 1'b0);
    send_item(8'h41, 1'b0, 1'b0);
    send_item(8'h42, 1'b0, 1'b1);
    // too short
    send_item(8'h00, 1'b0, 1'b1);
    // string ended by a byteless end marker
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h7E, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    quiesce();

    // a lone query never matches the empty string
    dir_pat = '0;
    dir_pat = with_byte(dir_pat, 0, QUERY_BYTE);
    load_pattern(6'd1, dir_pat);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b0, 1'b1);
    quiesce();

    // a lone star matches the empty string and any byte
    dir_pat = with_byte(dir_pat, 0, STAR_BYTE);
    load_pattern(6'd1, dir_pat);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h80, 1'b0, 1'b1);

    // random phases, each with its own pattern and idling mix
    items_sent = 0;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      quiesce();
      if (items_sent >= ITEM_TARGET - QUIET_TAIL) begin
        // closing stretch runs at full rate on both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = 10 * $urandom_range(0, 3);
        rx_idle_pct = 10 * $urandom_range(0, 3);
      end
      random_pattern(phase == 1);
      // short strings under a long receiver hold-off fill the block up
      if (phase == 1) hold_req = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) send_string($urandom_range(0, 3) != 0);
      phase++;
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    drain_cycles = 0;
    while (pending_results != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_results != 0) $error("%0d verdicts never arrived", pending_results);

    if (check_errors == 0 && pending_results == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== wildcard_glob_matcher.f =====
+incdir+src
src/wgm_pkg.sv
src/wgm_closure.sv
src/wgm_core.sv
src/wildcard_glob_matcher.sv
tb/wgm_match_checker.sv
tb/tb_wildcard_glob_matcher.sv
